// File: hw/rtl/gcr_pkg.sv
`timescale 1ns / 1ps

package gcr_pkg;

    // group mode codes
    typedef enum logic [1:0] {
        MODE_FIRST    = 2'd0,
        MODE_DATA     = 2'd1,
        MODE_FINAL    = 2'd2,
        MODE_CHECKSUM = 2'd3
    } mode_t;

    localparam logic [7:0] FINAL_FILL_CODE = 8'h96;
    localparam logic [7:0] EPI_FIRST       = 8'hDE;
    localparam logic [7:0] EPI_SECOND      = 8'hAA;
    localparam logic [7:0] TABLE_BASE      = 8'h90;
    localparam int         TABLE_DEPTH     = 112;

    // index of the last result of a group
    typedef logic [1:0] res_idx_t;

    localparam res_idx_t IDX_TWO   = 2'd1;
    localparam res_idx_t IDX_THREE = 2'd2;
    localparam res_idx_t IDX_ONE   = 2'd0;

    // one decoded group, as handed to the output buffer
    typedef struct packed {
        logic [2:0][7:0] data;
        res_idx_t        last_idx;
        logic            status;
        logic            good;
    } group_t;

    // inverse code table for disk bytes 0x90..0xFF
    localparam logic [5:0] INV_TABLE [0:TABLE_DEPTH-1] = '{
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h01,
        6'h00, 6'h00, 6'h02, 6'h03, 6'h00, 6'h04, 6'h05, 6'h06,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h07, 6'h08,
        6'h00, 6'h00, 6'h00, 6'h09, 6'h0a, 6'h0b, 6'h0c, 6'h0d,
        6'h00, 6'h00, 6'h0e, 6'h0f, 6'h10, 6'h11, 6'h12, 6'h13,
        6'h00, 6'h14, 6'h15, 6'h16, 6'h17, 6'h18, 6'h19, 6'h1a,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00,
        6'h00, 6'h00, 6'h00, 6'h1b, 6'h00, 6'h1c, 6'h1d, 6'h1e,
        6'h00, 6'h00, 6'h00, 6'h1f, 6'h00, 6'h00, 6'h20, 6'h21,
        6'h00, 6'h22, 6'h23, 6'h24, 6'h25, 6'h26, 6'h27, 6'h28,
        6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h29, 6'h2a, 6'h2b,
        6'h00, 6'h2c, 6'h2d, 6'h2e, 6'h2f, 6'h30, 6'h31, 6'h32,
        6'h00, 6'h00, 6'h33, 6'h34, 6'h35, 6'h36, 6'h37, 6'h38,
        6'h00, 6'h39, 6'h3a, 6'h3b, 6'h3c, 6'h3d, 6'h3e, 6'h3f
    };

    // disk byte to 6-bit value, invalid codes give zero
    function automatic logic [5:0] six_of(input logic [7:0] code);
        logic [7:0] offs;
        offs = code - TABLE_BASE;
        if (code < TABLE_BASE) begin
            return 6'h00;
        end
        return INV_TABLE[offs[6:0]];
    endfunction

endpackage

// File: hw/rtl/gcr_dec_unit.sv
`timescale 1ns / 1ps

module gcr_dec_unit
    import gcr_pkg::*;
(
    input  mode_t      mode,
    input  logic [7:0] nib_a,
    input  logic [7:0] nib_b,
    input  logic [7:0] nib_c,
    input  logic [7:0] nib_d,
    input  logic [7:0] epilogue_first,
    input  logic [7:0] epilogue_second,
    input  logic [7:0] sum_first,
    input  logic [7:0] sum_second,
    input  logic [7:0] sum_rotating,
    output group_t     group,
    output logic [7:0] sum_first_next,
    output logic [7:0] sum_second_next,
    output logic [7:0] sum_rotating_next
);

    logic [7:0] fourth;
    logic [5:0] hi, lo_b, lo_c, lo_d;
    logic [7:0] x, y, z;
    logic [7:0] sf, ss, sr, rot;
    logic [7:0] va, vb, vc;
    logic [8:0] sa, sb;
    logic       good;

    // split the group into three raw bytes
    assign fourth = (mode == MODE_FINAL) ? FINAL_FILL_CODE : nib_d;
    assign hi     = six_of(nib_a);
    assign lo_b   = six_of(nib_b);
    assign lo_c   = six_of(nib_c);
    assign lo_d   = six_of(fourth);
    assign x      = {hi[5:4], lo_b};
    assign y      = {hi[3:2], lo_c};
    assign z      = {hi[1:0], lo_d};

    // a first group starts from cleared sums
    assign sf = (mode == MODE_FIRST) ? 8'h00 : sum_first;
    assign ss = (mode == MODE_FIRST) ? 8'h00 : sum_second;
    assign sr = (mode == MODE_FIRST) ? 8'h00 : sum_rotating;

    // descramble against the running checksum
    assign rot = {sr[6:0], sr[7]};
    assign va  = x ^ rot;
    assign sa  = {1'b0, sf} + {1'b0, va} + {8'h00, rot[0]};
    assign vb  = y ^ sa[7:0];
    assign sb  = {1'b0, ss} + {1'b0, vb} + {8'h00, sa[8]};
    assign vc  = z ^ sb[7:0];

    // checksum group verdict
    assign good = (x == sum_first) && (y == sum_second) && (z == sum_rotating)
               && (epilogue_first == EPI_FIRST) && (epilogue_second == EPI_SECOND);

    always_comb begin
        group             = '0;
        sum_first_next    = sa[7:0];
        sum_second_next   = sb[7:0];
        sum_rotating_next = rot + vc + {7'h00, sb[8]};
        case (mode)
            MODE_CHECKSUM: begin
                group.status      = 1'b1;
                group.good        = good;
                group.last_idx    = IDX_ONE;
                sum_first_next    = sum_first;
                sum_second_next   = sum_second;
                sum_rotating_next = sum_rotating;
            end
            MODE_FINAL: begin
                group.data[0]     = va;
                group.data[1]     = vb;
                group.last_idx    = IDX_TWO;
                sum_rotating_next = rot;
            end
            default: begin
                group.data[0]  = va;
                group.data[1]  = vb;
                group.data[2]  = vc;
                group.last_idx = IDX_THREE;
            end
        endcase
    end

endmodule

// File: hw/rtl/gcr_out_buf.sv
`timescale 1ns / 1ps

module gcr_out_buf
    import gcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,
    input  group_t      group,
    output logic        free,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,
    output logic        m_tlast,
    output logic        m_tuser
);

    group_t   group_reg;
    logic     valid_reg, valid_next;
    res_idx_t idx_reg, idx_next;
    logic     at_last;
    logic     taken;

    assign at_last = (idx_reg == group_reg.last_idx);
    assign taken   = valid_reg && m_tready;
    // a new group may enter once the current last result is leaving
    assign free    = !valid_reg || (taken && at_last);

    // result index and occupancy
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = IDX_ONE;
        end else if (taken) begin
            if (at_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= IDX_ONE;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    // group payload
    always_ff @(posedge aclk) begin
        if (load) begin
            group_reg <= group;
        end
    end

    // result transaction
    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'h00, group_reg.good,
                       (idx_reg == IDX_THREE) ? group_reg.data[2] :
                       (idx_reg == IDX_TWO)   ? group_reg.data[1] : group_reg.data[0]};
    assign m_tlast  = at_last;
    assign m_tuser  = group_reg.status;

endmodule

// File: hw/rtl/gcr_sector_data_field_decoder.sv
`timescale 1ns / 1ps
// channel   direction  payload
// s_        in         tdata: nib_a, nib_b, nib_c, nib_d, epilogue_first, epilogue_second
//                      tuser: mode
// m_        out        tdata: data_byte, sector_good; tuser: is_status; tlast: last
//
// a group is decoded in the cycle it is accepted and held in an output register
// results leave one per cycle while m_tready is high: three per data group, two for a final group,
// one for a checksum group; apart from m_tready stalls, the output register is the only rate limit
// the next group is accepted in the cycle the previous group's last result is taken
// reset clears the running sums and empties the output register
// a stall on m_tready holds the current result and holds s_tready low

module gcr_sector_data_field_decoder
    import gcr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // nib_a, nib_b, nib_c, nib_d, epilogue_first, epilogue_second
    input  logic [1:0]  s_tuser,   // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // data_byte, sector_good, zero fill
    output logic        m_tlast,
    output logic        m_tuser    // is_status
);

    logic [7:0] sum_first_reg, sum_first_next;
    logic [7:0] sum_second_reg, sum_second_next;
    logic [7:0] sum_rotating_reg, sum_rotating_next;
    group_t     group;
    logic       free;
    logic       s_fire;

    assign s_tready = free;
    assign s_fire   = s_tvalid && free;

    // decode and checksum update
    gcr_dec_unit u_dec (
        .mode              (mode_t'(s_tuser)),
        .nib_a             (s_tdata[7:0]),
        .nib_b             (s_tdata[15:8]),
        .nib_c             (s_tdata[23:16]),
        .nib_d             (s_tdata[31:24]),
        .epilogue_first    (s_tdata[39:32]),
        .epilogue_second   (s_tdata[47:40]),
        .sum_first         (sum_first_reg),
        .sum_second        (sum_second_reg),
        .sum_rotating      (sum_rotating_reg),
        .group             (group),
        .sum_first_next    (sum_first_next),
        .sum_second_next   (sum_second_next),
        .sum_rotating_next (sum_rotating_next)
    );

    // running checksum
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_first_reg    <= 8'h00;
            sum_second_reg   <= 8'h00;
            sum_rotating_reg <= 8'h00;
        end else if (s_fire) begin
            sum_first_reg    <= sum_first_next;
            sum_second_reg   <= sum_second_next;
            sum_rotating_reg <= sum_rotating_next;
        end
    end

    // result serializer
    gcr_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (s_fire),
        .group    (group),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // a status result is always a group's only result
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tlast && m_tdata[7:0] == 8'h00))
        else $error("status result not alone or carries data");

    // data results never claim a good sector
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> !m_tdata[8])
        else $error("data result with sector_good set");

    // a checksum group leaves the sums untouched
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == MODE_CHECKSUM) |=>
        ($stable(sum_first_reg) && $stable(sum_second_reg) && $stable(sum_rotating_reg)))
        else $error("checksum group changed the running sums");

    // no input taken while a non-final result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input accepted before group was drained");

endmodule
